// ----- sv/text_mode_line_renderer_top_defines.svh -----
// assertion macros used by the text-mode line renderer back end
`ifndef TEXT_MODE_LINE_RENDERER_TOP_DEFINES_SVH
`define TEXT_MODE_LINE_RENDERER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define TMLR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define TMLR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TMLR_ASSERT_IMP(lbl, ante, cons, msg)
`define TMLR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/tmlr_pkg.sv -----
// shared types and constants of the text-mode line renderer
package tmlr_pkg;

  // widest cell address over all legal screen sizes (64 rows x 128 columns)
  localparam int CELL_AW   = 13;
  localparam int FONT_AW   = 11;
  localparam int CMD_DEPTH = 4;
  localparam int CMD_AW    = 2;
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_AW     = 2;

  localparam logic [7:0]  SPACE_CODE     = 8'h20;
  localparam logic [15:0] PALETTE0_RESET = 16'h00DE;

  // item kinds, carried on tuser and through the command queue
  typedef enum logic [1:0] {
    OP_CELL   = 2'd0,
    OP_FONT   = 2'd1,
    OP_PAL    = 2'd2,
    OP_RENDER = 2'd3
  } op_t;

  // one classified command between front and back
  typedef struct packed {
    op_t                  op;
    logic [CELL_AW-1:0]   addr;
    logic [15:0]          data;
    logic [2:0]           line;
  } cmd_t;

  // one result word waiting for the receiver
  typedef struct packed {
    logic        last;
    logic [63:0] pixels;
  } out_word_t;

endpackage

// ----- sv/text_mode_line_renderer_top.sv -----
// top level of the 8x8 text-mode line renderer
//
// Input channel in_*: one word per item; in_tuser selects the kind (cell write,
// font row write, palette write, render line), in_tdata carries the fields.
// Output channel out_*: one 64-bit word of eight pixels per rendered cell,
// out_tlast marks the last cell of the half line.
// A render of a half line walks COLUMNS/2 cells (25 at the default width),
// one cell per cycle through the cell, font and palette reads while the
// output queue has room. out_tvalid for the first result word rises once
// the render word has passed the command queue, dispatch, the cell read
// and the font and palette read into the output queue.
// A four-entry command queue lets the input keep filling while a line is
// being rendered; a four-entry output queue holds finished words.
// After reset the cell store is swept to spaces with attribute zero, one cell
// per cycle; in_tready stays low during the sweep.
// When the receiver stalls, cell reads pause as the output queue fills, and
// the input stalls once the command queue is full.
module text_mode_line_renderer_top #(
  parameter int COLUMNS = 50,
  parameter int ROWS    = 37
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cell_row, cell_column, char_code, attribute, glyph_row, glyph_bits,
  // palette_index, palette_value, scan_line, second_half, zero pad
  input  logic [79:0] in_tdata,
  // kind
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixels
  output logic [63:0] out_tdata,
  output logic        out_tlast
);

  tmlr_pkg::cmd_t push_cmd;
  tmlr_pkg::cmd_t head_cmd;
  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  logic           q_full;
  logic           back_busy;

  // classifier
  tmlr_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .back_busy (back_busy),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // command queue
  tmlr_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  // executor
  tmlr_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .busy       (back_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- sv/tmlr_cmd_fifo.sv -----
// short command queue between the front classifier and the back executor
module tmlr_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tmlr_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output tmlr_pkg::cmd_t  head_cmd,
  output logic            empty,
  output logic            full
);

  tmlr_pkg::cmd_t                 mem_r [tmlr_pkg::CMD_DEPTH];
  logic [tmlr_pkg::CMD_AW-1:0]    wr_ptr_r;
  logic [tmlr_pkg::CMD_AW-1:0]    rd_ptr_r;
  logic [tmlr_pkg::CMD_AW:0]      cnt_r;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (tmlr_pkg::CMD_AW+1)'(tmlr_pkg::CMD_DEPTH));
  assign head_cmd = mem_r[rd_ptr_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- sv/tmlr_front.sv -----
// input side: accepts words, range-checks them and forms queue commands
module tmlr_front #(
  parameter int COLUMNS = 50,
  parameter int ROWS    = 37
) (
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [79:0]     in_tdata,
  input  logic [1:0]      in_tuser,
  input  logic            q_full,
  input  logic            back_busy,
  output logic            q_push,
  output tmlr_pkg::cmd_t  q_cmd
);

  localparam int HALF = COLUMNS / 2;

  logic [5:0]  cell_row;
  logic [6:0]  cell_column;
  logic [7:0]  char_code;
  logic [7:0]  attribute;
  logic [2:0]  glyph_row;
  logic [7:0]  glyph_bits;
  logic [7:0]  palette_index;
  logic [15:0] palette_value;
  logic [8:0]  scan_line;
  logic        second_half;
  logic [5:0]  text_row;
  logic        keep;
  tmlr_pkg::op_t kind;

  // unpack the word
  assign kind          = tmlr_pkg::op_t'(in_tuser);
  assign cell_row      = in_tdata[5:0];
  assign cell_column   = in_tdata[12:6];
  assign char_code     = in_tdata[20:13];
  assign attribute     = in_tdata[28:21];
  assign glyph_row     = in_tdata[31:29];
  assign glyph_bits    = in_tdata[39:32];
  assign palette_index = in_tdata[47:40];
  assign palette_value = in_tdata[63:48];
  assign scan_line     = in_tdata[72:64];
  assign second_half   = in_tdata[73];
  assign text_row      = scan_line[8:3];

  assign in_tready = !q_full && !back_busy;
  assign q_push    = in_tvalid && in_tready && keep;

  // classify and build the command; off-screen items are dropped here
  always_comb begin
    q_cmd      = '0;
    q_cmd.op   = kind;
    keep       = 1'b1;
    unique case (kind)
      tmlr_pkg::OP_CELL: begin
        keep       = (7'(cell_row) < 7'(ROWS)) && (8'(cell_column) < 8'(COLUMNS));
        q_cmd.addr = tmlr_pkg::CELL_AW'(cell_row) * tmlr_pkg::CELL_AW'(COLUMNS)
                   + tmlr_pkg::CELL_AW'(cell_column);
        q_cmd.data = {attribute, char_code};
      end
      tmlr_pkg::OP_FONT: begin
        q_cmd.addr = tmlr_pkg::CELL_AW'({char_code, glyph_row});
        q_cmd.data = {8'h00, glyph_bits};
      end
      tmlr_pkg::OP_PAL: begin
        q_cmd.addr = tmlr_pkg::CELL_AW'(palette_index);
        q_cmd.data = palette_value;
      end
      tmlr_pkg::OP_RENDER: begin
        keep       = (7'(text_row) < 7'(ROWS));
        q_cmd.addr = tmlr_pkg::CELL_AW'(text_row) * tmlr_pkg::CELL_AW'(COLUMNS)
                   + (second_half ? tmlr_pkg::CELL_AW'(HALF) : '0);
        q_cmd.line = scan_line[2:0];
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/tmlr_back.sv -----
// back side: stores, clear sweep, render pipeline and output queue
`include "text_mode_line_renderer_top_defines.svh"

module tmlr_back #(
  parameter int COLUMNS = 50,
  parameter int ROWS    = 37
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tmlr_pkg::cmd_t  head_cmd,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            busy,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [63:0]     out_tdata,
  output logic            out_tlast
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int CAW   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int HALF  = COLUMNS / 2;
  localparam int CW    = (HALF > 1) ? $clog2(HALF) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_RENDER
  } state_t;

  state_t              st_r;
  logic [CAW-1:0]      clr_addr_r;
  logic [CAW-1:0]      addr_r;
  logic [CW-1:0]       idx_r;
  logic [2:0]          line_r;

  // stores
  logic [15:0]         cell_mem [CELLS];
  logic [7:0]          font_mem [2**tmlr_pkg::FONT_AW];
  logic [15:0]         pal_mem  [256];
  logic [255:0]        pal_vld_r;

  // pipeline stage a: cell read
  logic                va_r;
  logic                a_last_r;
  logic [2:0]          a_line_r;
  logic [15:0]         cell_q;

  // pipeline stage b: font and palette read
  logic                vb_r;
  logic                b_last_r;
  logic [7:0]          font_q;
  logic [15:0]         pal_q;
  logic                pal_vq;
  logic                pal_zq;

  // output queue
  tmlr_pkg::out_word_t oq_r [tmlr_pkg::OQ_DEPTH];
  logic [tmlr_pkg::OQ_AW-1:0] oq_wr_r;
  logic [tmlr_pkg::OQ_AW-1:0] oq_rd_r;
  logic [tmlr_pkg::OQ_AW:0]   oq_cnt_r;

  logic                clearing;
  logic                issue;
  logic                last_issue;
  logic                oq_push;
  logic                oq_pop;
  logic                cm_we;
  logic [CAW-1:0]      cm_waddr;
  logic [15:0]         cm_wdata;
  logic [15:0]         pal_pair;
  logic [3:0]          pending;
  tmlr_pkg::out_word_t oq_in;

  assign clearing   = (st_r == ST_CLEAR);
  assign busy       = clearing;
  assign q_pop      = (st_r == ST_RUN) && !q_empty;

  // credit check: queue fill plus words in flight must leave room
  assign pending    = 4'(oq_cnt_r) + 4'(va_r) + 4'(vb_r);
  assign issue      = (st_r == ST_RENDER) && (pending < 4'(tmlr_pkg::OQ_DEPTH));
  assign last_issue = issue && (idx_r == CW'(HALF - 1));

  // sequencer: clear sweep, command dispatch, cell walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_CLEAR;
      clr_addr_r <= '0;
      addr_r     <= '0;
      idx_r      <= '0;
      line_r     <= '0;
    end else begin
      unique case (st_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == CAW'(CELLS - 1)) begin
            st_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (q_pop && head_cmd.op == tmlr_pkg::OP_RENDER) begin
            addr_r <= head_cmd.addr[CAW-1:0];
            idx_r  <= '0;
            line_r <= head_cmd.line;
            st_r   <= ST_RENDER;
          end
        end
        ST_RENDER: begin
          if (issue) begin
            addr_r <= addr_r + 1'b1;
            idx_r  <= idx_r + 1'b1;
            if (last_issue) begin
              st_r <= ST_RUN;
            end
          end
        end
        default: begin
          st_r <= ST_CLEAR;
        end
      endcase
    end
  end

  // cell store: sweep writes spaces with attribute zero
  assign cm_we    = clearing || (q_pop && head_cmd.op == tmlr_pkg::OP_CELL);
  assign cm_waddr = clearing ? clr_addr_r : head_cmd.addr[CAW-1:0];
  assign cm_wdata = clearing ? {8'h00, tmlr_pkg::SPACE_CODE} : head_cmd.data;

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cell_mem[cm_waddr] <= cm_wdata;
    end
    cell_q <= cell_mem[addr_r];
  end

  // font store
  always_ff @(posedge clk) begin
    if (q_pop && head_cmd.op == tmlr_pkg::OP_FONT) begin
      font_mem[head_cmd.addr[tmlr_pkg::FONT_AW-1:0]] <= head_cmd.data[7:0];
    end
    font_q <= font_mem[{cell_q[7:0], a_line_r}];
  end

  // palette store
  always_ff @(posedge clk) begin
    if (q_pop && head_cmd.op == tmlr_pkg::OP_PAL) begin
      pal_mem[head_cmd.addr[7:0]] <= head_cmd.data;
    end
    pal_q <= pal_mem[cell_q[15:8]];
  end

  // palette written flags; an unwritten entry reads as zero, entry zero as PALETTE0_RESET
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_vld_r <= '0;
    end else if (q_pop && head_cmd.op == tmlr_pkg::OP_PAL) begin
      pal_vld_r[head_cmd.addr[7:0]] <= 1'b1;
    end
  end

  // pipeline side data
  always_ff @(posedge clk) begin
    a_last_r <= last_issue;
    a_line_r <= line_r;
    b_last_r <= a_last_r;
    pal_vq   <= pal_vld_r[cell_q[15:8]];
    pal_zq   <= (cell_q[15:8] == 8'h00);
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= issue;
      vb_r <= va_r;
    end
  end

  // pixel expansion: pixel k from glyph bit 7-k
  assign pal_pair = pal_vq ? pal_q : (pal_zq ? tmlr_pkg::PALETTE0_RESET : 16'h0000);

  always_comb begin
    oq_in.last = b_last_r;
    for (int k = 0; k < 8; k++) begin
      oq_in.pixels[8*k +: 8] = font_q[7-k] ? pal_pair[15:8] : pal_pair[7:0];
    end
  end

  // output queue
  assign oq_push    = vb_r;
  assign oq_pop     = out_tvalid && out_tready;
  assign out_tvalid = (oq_cnt_r != '0);
  assign out_tdata  = oq_r[oq_rd_r].pixels;
  assign out_tlast  = oq_r[oq_rd_r].last;

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= oq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  // credit scheme keeps the output queue from overflowing
  `TMLR_ASSERT_IMP(a_oq_no_overflow,
    oq_push && !oq_pop,
    oq_cnt_r != (tmlr_pkg::OQ_AW+1)'(tmlr_pkg::OQ_DEPTH),
    "output queue overflow")
  // nothing reaches the output during the clear sweep
  `TMLR_ASSERT_IMP(a_clear_quiet,
    st_r == ST_CLEAR,
    !va_r && !vb_r && oq_cnt_r == '0,
    "result produced during clear sweep")
  // the last cell of a line hands control back to dispatch
  `TMLR_ASSERT_NXT(a_last_ends_render,
    last_issue,
    st_r == ST_RUN && a_last_r,
    "render did not end after last cell")
  // commands are taken only in dispatch
  `TMLR_ASSERT_IMP(a_pop_only_run,
    q_pop,
    st_r == ST_RUN && !issue,
    "command popped outside dispatch")

endmodule
